>>> rtl/core/rle_stream_decoder_assert.svh
// Assertion macros used by the decoder checker.
`ifndef RLE_STREAM_DECODER_ASSERT_SVH
`define RLE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rsd_pkg.sv
// Shared types, constants and helpers of the run-length stream decoder.
`timescale 1ns / 1ps
package rsd_pkg;

  localparam int OUT_LANES_DEF = 4;
  localparam int MAX_LANES     = 4;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [2:0] HDR_MAGIC_LEN = 3'd4;
  localparam logic [2:0] HDR_LEN       = 3'd5;

  localparam logic [7:0] CTRL_RUN_BIT = 8'h80;
  localparam logic [7:0] CTRL_LEN_MSK = 8'h7F;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LIT,
    OP_RUN
  } rsd_op_t;

  // One work command handed from the front to the back.
  typedef struct packed {
    rsd_op_t    op;
    logic [7:0] value;
    logic [7:0] run_len;
    logic       has_status;
    logic [1:0] status;
  } rsd_cmd_t;

  function automatic logic [7:0] magic_at(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h41;  // 'A'
      2'd1:    m = 8'h52;  // 'R'
      2'd2:    m = 8'h30;  // '0'
      2'd3:    m = 8'h31;  // '1'
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/rle_stream_decoder.sv
// Top level of the run-length stream decoder.
// Usage:
//   Input channel (in_valid / in_stall): one compressed byte per transfer on
//   data_byte, final_byte high on the last byte of a stream. A stream opens
//   with 'A','R','0','1' and one skipped byte, then control/data bytes.
//   Output channel (out_valid / out_stall): literal bytes one per transfer,
//   runs packed up to min(OUT_LANES, 4) bytes per transfer with run_end on the
//   last chunk, and after the final byte one status transfer (stream_end high,
//   byte_count 0, status 0 ok, 1 bad/short header, 2 truncated).
// Timing:
//   The front takes one byte per cycle while the four-entry command queue
//   has room. The back loads each command from the queue while idle, then
//   issues its transfers one per cycle while out_stall is low: a literal
//   byte takes one transfer, a run of L bytes ceil(L / lanes), and a status
//   transfer follows the data of the same byte or stands alone. The back
//   takes no new command until the current one is done.
//   When out_stall is high the output register holds; the back stops, the
//   queue fills and in_stall rises.
// Reset: rst clears the parser state, the queue and the output valid.
`timescale 1ns / 1ps
module rle_stream_decoder #(
  parameter int OUT_LANES = rsd_pkg::OUT_LANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_bytes,
  output logic [2:0]  byte_count,
  output logic        run_end,
  output logic        stream_end,
  output logic [1:0]  status
);
  import rsd_pkg::*;

  rsd_cmd_t push_cmd;
  rsd_cmd_t head;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  rsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  rsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rsd_back #(
    .OUT_LANES (OUT_LANES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bytes  (out_bytes),
    .byte_count (byte_count),
    .run_end    (run_end),
    .stream_end (stream_end),
    .status     (status)
  );

endmodule

>>> rtl/core/rsd_front.sv
// Front end: header check, control byte parsing and command generation.
`timescale 1ns / 1ps
module rsd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  logic              q_full,
  output logic              push,
  output rsd_pkg::rsd_cmd_t cmd
);
  import rsd_pkg::*;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_RUNVAL,
    PH_LIT
  } phase_t;

  logic [2:0] header_position, header_position_next;
  phase_t     decode_phase, decode_phase_next;
  logic [7:0] literal_left, literal_left_next;
  logic [7:0] pending_run_length, pending_run_length_next;
  logic [1:0] error_code, error_code_next;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    header_position_next    = header_position;
    decode_phase_next       = decode_phase;
    literal_left_next       = literal_left;
    pending_run_length_next = pending_run_length;
    error_code_next         = error_code;
    cmd.op                  = OP_NONE;
    cmd.value               = data_byte;
    cmd.run_len             = pending_run_length;
    cmd.has_status          = final_byte;
    cmd.status              = ST_OK;

    if (error_code == ST_OK) begin
      if (header_position < HDR_LEN) begin
        if (header_position < HDR_MAGIC_LEN &&
            data_byte != magic_at(header_position[1:0])) begin
          error_code_next = ST_HDR;
        end else begin
          header_position_next = header_position + 3'd1;
        end
      end else begin
        case (decode_phase)
          PH_CTRL: begin
            if ((data_byte & CTRL_RUN_BIT) != 8'h00) begin
              pending_run_length_next = (data_byte & CTRL_LEN_MSK) + 8'd1;
              decode_phase_next       = PH_RUNVAL;
            end else begin
              literal_left_next = (data_byte & CTRL_LEN_MSK) + 8'd1;
              decode_phase_next = PH_LIT;
            end
          end
          PH_RUNVAL: begin
            cmd.op                  = OP_RUN;
            pending_run_length_next = 8'd0;
            decode_phase_next       = PH_CTRL;
          end
          PH_LIT: begin
            cmd.op = OP_LIT;
            if (literal_left != 8'd0) begin
              literal_left_next = literal_left - 8'd1;
            end
            if (literal_left <= 8'd1) begin
              decode_phase_next = PH_CTRL;
            end
          end
          default: decode_phase_next = PH_CTRL;
        endcase
      end
    end

    if (error_code_next != ST_OK) begin
      cmd.status = error_code_next;
    end else if (header_position_next < HDR_LEN) begin
      cmd.status = ST_HDR;
    end else if (decode_phase_next != PH_CTRL) begin
      cmd.status = ST_TRUNC;
    end
  end

  assign push = accept && (cmd.op != OP_NONE || final_byte);

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      // the final byte returns the parser to its reset state
      header_position    <= 3'd0;
      decode_phase       <= PH_CTRL;
      literal_left       <= 8'd0;
      pending_run_length <= 8'd0;
      error_code         <= ST_OK;
    end else if (accept) begin
      header_position    <= header_position_next;
      decode_phase       <= decode_phase_next;
      literal_left       <= literal_left_next;
      pending_run_length <= pending_run_length_next;
      error_code         <= error_code_next;
    end
  end

endmodule

>>> rtl/core/rsd_queue.sv
// Small command queue between the front and back ends.
`timescale 1ns / 1ps
module rsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rsd_pkg::rsd_cmd_t push_cmd,
  input  logic              pop,
  output rsd_pkg::rsd_cmd_t head,
  output logic              empty,
  output logic              full
);
  import rsd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  rsd_cmd_t      slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/rsd_back.sv
// Back end: expands commands into packed result transfers.
`timescale 1ns / 1ps
module rsd_back #(
  parameter int OUT_LANES = rsd_pkg::OUT_LANES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rsd_pkg::rsd_cmd_t head,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_bytes,
  output logic [2:0]        byte_count,
  output logic              run_end,
  output logic              stream_end,
  output logic [1:0]        status
);
  import rsd_pkg::*;

  localparam int LANES = (OUT_LANES > MAX_LANES) ? MAX_LANES :
                         ((OUT_LANES < 1) ? 1 : OUT_LANES);
  localparam logic [2:0] LANES_N = 3'(LANES);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DATA,
    B_STAT
  } bstate_t;

  bstate_t    bstate;
  rsd_cmd_t   cur;
  logic [7:0] left;
  logic [7:0] left_next;
  logic [2:0] chunk;
  logic [31:0] word;
  logic       out_free;

  assign out_free  = !out_valid || !out_stall;
  assign pop       = (bstate == B_IDLE) && !q_empty;
  assign chunk     = (left < 8'(LANES)) ? left[2:0] : LANES_N;
  assign left_next = left - 8'(chunk);

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      word[8*i +: 8] = (3'(i) < chunk) ? cur.value : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (bstate)
        B_IDLE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
          if (!q_empty) begin
            cur    <= head;
            left   <= (head.op == OP_RUN) ? head.run_len : 8'd1;
            bstate <= (head.op == OP_NONE) ? B_STAT : B_DATA;
          end
        end
        B_DATA: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_bytes  <= word;
            byte_count <= chunk;
            run_end    <= (left_next == 8'd0);
            stream_end <= 1'b0;
            status     <= ST_OK;
            left       <= left_next;
            if (left_next == 8'd0) begin
              bstate <= cur.has_status ? B_STAT : B_IDLE;
            end
          end
        end
        B_STAT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_bytes  <= 32'h0;
            byte_count <= 3'd0;
            run_end    <= 1'b0;
            stream_end <= 1'b1;
            status     <= cur.status;
            bstate     <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/rsd_checker.sv
// Port-level checker for the run-length stream decoder, bound to the top level.
`timescale 1ns / 1ps
`include "rle_stream_decoder_assert.svh"
module rsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_bytes,
  input logic [2:0]  byte_count,
  input logic        run_end,
  input logic        stream_end,
  input logic [1:0]  status
);
  import rsd_pkg::*;

  `RSD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_bytes) && $stable(byte_count) && $stable(status), "stalled output transfer changed")
  `RSD_ASSERT_IMP(a_data_no_status, out_valid && byte_count != 3'd0, status == ST_OK && !stream_end, "data transfer carries status")
  `RSD_ASSERT_IMP(a_status_empty, out_valid && stream_end, byte_count == 3'd0 && !run_end && out_bytes == 32'h0, "status transfer carries data")
  `RSD_ASSERT_IMP(a_run_repeat, out_valid && byte_count > 3'd1, out_bytes[15:8] == out_bytes[7:0], "packed run lanes differ")

endmodule

bind rle_stream_decoder rsd_checker u_rsd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_bytes  (out_bytes),
  .byte_count (byte_count),
  .run_end    (run_end),
  .stream_end (stream_end),
  .status     (status)
);
